// ----- src/sgtb_pkg.sv -----
// Shared constants for the scaled glyph text blitter.
// Field widths and the glyph geometry; no dependencies.
package sgtb_pkg;

   localparam int SCALE_BITS = 4;
   localparam int COLOR_BITS = 24;
   localparam int CODE_BITS = 8;
   localparam int GLYPH_SIDE = 8;
   localparam int GLYPH_BITS = GLYPH_SIDE * GLYPH_SIDE;
   localparam int COL_BITS = $clog2(GLYPH_SIDE);
   localparam int MAX_CELLS = 8;
   localparam int OFF_BITS = $clog2(MAX_CELLS * ((1 << SCALE_BITS) - 1) + 1);

   typedef logic [GLYPH_BITS-1:0] glyph_type;

endpackage

// ----- src/sgtb_font_rom.sv -----
// Fixed 8x8 font: maps a character code to its glyph bits, row 0 in the top byte.
// Uses sgtb_pkg for the code and glyph widths.
module sgtb_font_rom
   import sgtb_pkg::*;
(
   input  logic [CODE_BITS-1:0] char_code,
   output glyph_type            glyph
);

   always_comb begin
      unique case (char_code)
         8'd65:   glyph = 64'h70_88_88_F8_88_88_88_00;
         8'd67:   glyph = 64'h70_88_80_80_80_88_70_00;
         8'd68:   glyph = 64'hF0_88_88_88_88_88_F0_00;
         8'd69:   glyph = 64'hF8_80_80_F0_80_80_F8_00;
         8'd71:   glyph = 64'h70_88_80_B8_88_88_70_00;
         8'd72:   glyph = 64'h88_88_88_F8_88_88_88_00;
         8'd73:   glyph = 64'h70_20_20_20_20_20_70_00;
         8'd75:   glyph = 64'h88_90_A0_C0_A0_90_88_00;
         8'd77:   glyph = 64'h88_D8_A8_A8_88_88_88_00;
         8'd78:   glyph = 64'h88_C8_A8_98_88_88_88_00;
         8'd79:   glyph = 64'h70_88_88_88_88_88_70_00;
         8'd80:   glyph = 64'hF0_88_88_F0_80_80_80_00;
         8'd82:   glyph = 64'hF0_88_88_F0_A0_90_88_00;
         8'd83:   glyph = 64'h70_88_80_70_08_88_70_00;
         8'd84:   glyph = 64'hF8_20_20_20_20_20_20_00;
         8'd85:   glyph = 64'h88_88_88_88_88_88_70_00;
         8'd86:   glyph = 64'h88_88_88_88_88_50_20_00;
         8'd87:   glyph = 64'h88_88_88_A8_A8_D8_88_00;
         8'd89:   glyph = 64'h88_88_50_20_20_20_20_00;
         8'd97:   glyph = 64'h00_00_70_08_78_88_78_00;
         8'd99:   glyph = 64'h00_00_70_80_80_88_70_00;
         8'd100:  glyph = 64'h08_08_78_88_88_88_78_00;
         8'd101:  glyph = 64'h00_00_70_88_F0_80_70_00;
         8'd102:  glyph = 64'h30_48_40_E0_40_40_40_00;
         8'd103:  glyph = 64'h00_00_78_88_88_78_08_70;
         8'd104:  glyph = 64'h80_80_F0_88_88_88_88_00;
         8'd105:  glyph = 64'h20_00_60_20_20_20_70_00;
         8'd107:  glyph = 64'h80_80_90_A0_C0_A0_90_00;
         8'd108:  glyph = 64'h60_20_20_20_20_20_70_00;
         8'd109:  glyph = 64'h00_00_D0_A8_A8_A8_A8_00;
         8'd110:  glyph = 64'h00_00_F0_88_88_88_88_00;
         8'd111:  glyph = 64'h00_00_70_88_88_88_70_00;
         8'd112:  glyph = 64'h00_00_F0_88_88_F0_80_80;
         8'd114:  glyph = 64'h00_00_F0_88_80_80_80_00;
         8'd115:  glyph = 64'h00_00_70_80_70_08_F0_00;
         8'd116:  glyph = 64'h20_20_F8_20_20_20_18_00;
         8'd117:  glyph = 64'h00_00_88_88_88_88_78_00;
         8'd118:  glyph = 64'h00_00_88_88_88_50_20_00;
         8'd119:  glyph = 64'h00_00_88_88_A8_A8_50_00;
         8'd121:  glyph = 64'h00_00_88_88_78_08_88_70;
         default: glyph = '0;
      endcase
   end

endmodule

// ----- src/sgtb_sat_add.sv -----
// Saturating coordinate adder shared by the blitter sequencer.
// Clamps sums above the coordinate range and flags the clamp; no dependencies.
module sgtb_sat_add #(
   parameter int A_BITS = 13,
   parameter int B_BITS = 12,
   parameter int COORD_BITS = 12
) (
   input  logic [A_BITS-1:0]     a,
   input  logic [B_BITS-1:0]     b,
   output logic [A_BITS:0]       sum,
   output logic [COORD_BITS-1:0] result,
   output logic                  clip
);

   assign sum = {1'b0, a} + (A_BITS + 1)'(b);
   assign clip = |sum[A_BITS:COORD_BITS];
   assign result = clip ? '1 : sum[COORD_BITS-1:0];

endmodule

// ----- src/scaled_glyph_text_blitter.sv -----
// Scaled glyph text blitter top level: sequencer, pen register and result register.
// Depends on sgtb_pkg, sgtb_font_rom and sgtb_sat_add.
//
// One input transfer on the req_ channel carries one character with the string
// origin, scale, color and a first-of-string flag. The block draws the glyph as
// one rsp_ transfer per set glyph bit, in row-major order, each a filled square
// of side scale; the last square of the character has rsp_last_block set.
// A character with a blank glyph produces no transfers but still moves the pen.
// Sequence: after acceptance a setup step adds the pen to the origin, the scan
// then steps through the glyph bits up to the last set bit (at most 64), finds
// the scan empty and the pen advances; only then is the next character accepted.
// The setup, the scan and the advance share the single saturating x adder.
// The first square passes the setup step and the scan, then the result register.
// req_stall is high from acceptance until the pen has advanced.
// The result register holds a square while rsp_stall is high; the scan waits on
// the next set bit until the register frees, so nothing is dropped.
// Reset clears the pen offset, the sequencer and the result valid flag.
module scaled_glyph_text_blitter
   import sgtb_pkg::*;
#(
   parameter int ADVANCE_CELLS = 6,
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CODE_BITS-1:0]  req_char_code,
   input  logic                  req_first_of_string,
   input  logic [COORD_BITS-1:0] req_origin_x,
   input  logic [COORD_BITS-1:0] req_origin_y,
   input  logic [SCALE_BITS-1:0] req_scale,
   input  logic [COLOR_BITS-1:0] req_ink_color,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_block_x,
   output logic [COORD_BITS-1:0] rsp_block_y,
   output logic [SCALE_BITS-1:0] rsp_block_size,
   output logic [COLOR_BITS-1:0] rsp_block_color,
   output logic                  rsp_clipped,
   output logic                  rsp_last_block
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BASE = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_ADV  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COORD_BITS-1:0] pen_ff, pen_in;
   glyph_type             glyph_ff, glyph_in;
   glyph_type             rom_glyph;
   logic [COORD_BITS-1:0] ox_ff, ox_in;
   logic [COORD_BITS-1:0] oy_ff, oy_in;
   logic [SCALE_BITS-1:0] scale_ff, scale_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [COORD_BITS:0]   base_ff, base_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [OFF_BITS-1:0]   col_off_ff, col_off_in;
   logic [OFF_BITS-1:0]   row_off_ff, row_off_in;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic [COORD_BITS-1:0] out_y_ff, out_y_in;
   logic [SCALE_BITS-1:0] out_size_ff, out_size_in;
   logic [COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                  out_clip_ff, out_clip_in;
   logic                  out_last_ff, out_last_in;

   logic [COORD_BITS:0]   xa;
   logic [COORD_BITS-1:0] xb;
   logic [COORD_BITS+1:0] x_sum;
   logic [COORD_BITS-1:0] x_res;
   logic                  x_clip;
   logic [COORD_BITS+1:0] y_sum;
   logic [COORD_BITS-1:0] y_res;
   logic                  y_clip;
   logic [OFF_BITS-1:0]   adv_amt;
   logic                  accept;
   logic                  out_free;
   logic                  load;
   logic                  step;

   sgtb_font_rom u_rom (
      .char_code (req_char_code),
      .glyph     (rom_glyph)
   );

   sgtb_sat_add #(
      .A_BITS     (COORD_BITS + 1),
      .B_BITS     (COORD_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_x_add (
      .a      (xa),
      .b      (xb),
      .sum    (x_sum),
      .result (x_res),
      .clip   (x_clip)
   );

   sgtb_sat_add #(
      .A_BITS     (COORD_BITS + 1),
      .B_BITS     (COORD_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_y_add (
      .a      ({1'b0, oy_ff}),
      .b      (COORD_BITS'(row_off_ff)),
      .sum    (y_sum),
      .result (y_res),
      .clip   (y_clip)
   );

   assign adv_amt = OFF_BITS'(ADVANCE_CELLS) * OFF_BITS'(scale_ff);
   assign accept = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign load = (state_ff == ST_SCAN) && (glyph_ff != '0) && glyph_ff[GLYPH_BITS-1] && out_free;
   assign step = (state_ff == ST_SCAN) && (glyph_ff != '0) &&
                 (!glyph_ff[GLYPH_BITS-1] || out_free);

   always_comb begin
      unique case (state_ff)
         ST_BASE: begin
            xa = {1'b0, ox_ff};
            xb = pen_ff;
         end
         ST_ADV: begin
            xa = {1'b0, pen_ff};
            xb = COORD_BITS'(adv_amt);
         end
         default: begin
            xa = base_ff;
            xb = COORD_BITS'(col_off_ff);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pen_in = pen_ff;
      glyph_in = glyph_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      scale_in = scale_ff;
      color_in = color_ff;
      base_in = base_ff;
      col_in = col_ff;
      col_off_in = col_off_ff;
      row_off_in = row_off_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BASE;
               glyph_in = rom_glyph;
               ox_in = req_origin_x;
               oy_in = req_origin_y;
               scale_in = req_scale;
               color_in = req_ink_color;
               col_in = '0;
               col_off_in = '0;
               row_off_in = '0;
               if (req_first_of_string) begin
                  pen_in = '0;
               end
            end
         end
         ST_BASE: begin
            base_in = x_sum[COORD_BITS:0];
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (glyph_ff == '0) begin
               state_in = ST_ADV;
            end else if (step) begin
               glyph_in = {glyph_ff[GLYPH_BITS-2:0], 1'b0};
               col_in = col_ff + 1'b1;
               if (col_ff == COL_BITS'(GLYPH_SIDE - 1)) begin
                  col_off_in = '0;
                  row_off_in = row_off_ff + OFF_BITS'(scale_ff);
               end else begin
                  col_off_in = col_off_ff + OFF_BITS'(scale_ff);
               end
            end
         end
         ST_ADV: begin
            pen_in = x_res;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_size_in = out_size_ff;
      out_color_in = out_color_ff;
      out_clip_in = out_clip_ff;
      out_last_in = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_x_in = x_res;
         out_y_in = y_res;
         out_size_in = scale_ff;
         out_color_in = color_ff;
         out_clip_in = x_clip || y_clip;
         out_last_in = (glyph_ff[GLYPH_BITS-2:0] == '0);
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pen_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pen_ff <= pen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      scale_ff <= scale_in;
      color_ff <= color_in;
      base_ff <= base_in;
      col_ff <= col_in;
      col_off_ff <= col_off_in;
      row_off_ff <= row_off_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_size_ff <= out_size_in;
      out_color_ff <= out_color_in;
      out_clip_ff <= out_clip_in;
      out_last_ff <= out_last_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_block_x = out_x_ff;
   assign rsp_block_y = out_y_ff;
   assign rsp_block_size = out_size_ff;
   assign rsp_block_color = out_color_ff;
   assign rsp_clipped = out_clip_ff;
   assign rsp_last_block = out_last_ff;

endmodule
